// ----- rtl/mvf_pkg.sv -----
// mvf_pkg: shared types, constants and helpers for the multimode value filter
// used by every module under rtl/; no dependencies
package mvf_pkg;

    localparam int VALUE_W  = 32;
    localparam int TIME_W   = 32;
    localparam int EL_W     = 16;
    localparam int Q_W      = 22;
    localparam int R_W      = 10;
    localparam int ELR_W    = EL_W + R_W;
    localparam int STEP_W   = 38;
    localparam int PROD_W   = 2 * VALUE_W;
    localparam int SUM_W    = 49;
    localparam int Q_FRAC   = 16;
    localparam int ADDR_W   = 4;

    localparam logic [TIME_W-1:0] EL_MAX = 32'd65535;

    // floor(x / 1000) by reciprocal: exact for x < 2^31
    localparam logic [31:0] RECIP_Q       = 32'd2199023256;
    localparam int          RECIP_Q_SHIFT = 41;
    // floor(x / 1000) by reciprocal: exact for x < 2^26
    localparam logic [26:0] RECIP_R       = 27'd68719477;
    localparam int          RECIP_R_SHIFT = 36;
    localparam int          RECIP_R_W     = 27;
    localparam logic [9:0]  DIV_K         = 10'd1000;

    localparam logic [32:0]        RATE_TOL = 33'd65;
    localparam logic signed [31:0] Q_ONE    = 32'sd65536;

    typedef enum logic [2:0] {
        MODE_DELAY    = 3'd0,
        MODE_DEBOUNCE = 3'd1,
        MODE_RATE     = 3'd2,
        MODE_DEADZONE = 3'd3,
        MODE_CLAMP    = 3'd4,
        MODE_SCALE    = 3'd5
    } mode_t;

    typedef enum logic [1:0] {
        REG_ENABLE  = 2'd0,
        REG_MODE    = 2'd1,
        REG_PARAM_A = 2'd2,
        REG_PARAM_B = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic               enable;
        logic [2:0]         mode;
        logic signed [31:0] param_a;
        logic signed [31:0] param_b;
    } cfg_t;

    function automatic logic signed [VALUE_W-1:0] sat32(input logic signed [SUM_W-1:0] v);
        logic signed [VALUE_W-1:0] r;
        if (v > 49'sd2147483647)
            r = 32'sh7FFFFFFF;
        else if (v < -49'sd2147483648)
            r = 32'sh80000000;
        else
            r = v[VALUE_W-1:0];
        return r;
    endfunction

endpackage

// ----- rtl/mvf_rate_step.sv -----
// mvf_rate_step: pipelined rate limit step floor(param_a * elapsed / 1000)
// depends on mvf_pkg; output aligned with the last pipeline stage of the top level
module mvf_rate_step (
    input  logic                          clk,
    input  logic                          adv,
    input  logic signed [31:0]            param_a,
    input  logic [mvf_pkg::EL_W-1:0]      el,
    output logic [mvf_pkg::STEP_W-1:0]    step
);

    logic [30:0]                       pa_pos;
    logic [62:0]                       q_full;
    logic [mvf_pkg::Q_W-1:0]           q_reg;
    logic [mvf_pkg::Q_W-1:0]           q_next;
    logic [mvf_pkg::R_W-1:0]           r_reg;
    logic [mvf_pkg::R_W-1:0]           r_next;
    logic [mvf_pkg::STEP_W-1:0]        elq_reg;
    logic [mvf_pkg::ELR_W-1:0]         elr_reg;
    logic [mvf_pkg::ELR_W+mvf_pkg::RECIP_R_W-1:0] elr_prod;
    logic [16:0]                       elr_quot;
    logic [mvf_pkg::STEP_W-1:0]        step_reg;
    logic [mvf_pkg::STEP_W-1:0]        step_next;

    // param_a = 1000*q + r, tracked from the register
    assign pa_pos   = (param_a > 32'sd0) ? param_a[30:0] : 31'd0;
    assign q_full   = 63'(pa_pos) * 63'(mvf_pkg::RECIP_Q);
    assign q_next   = q_full[mvf_pkg::RECIP_Q_SHIFT +: mvf_pkg::Q_W];
    assign r_next   = mvf_pkg::R_W'(32'(pa_pos) - 32'(q_reg) * 32'(mvf_pkg::DIV_K));

    assign elr_prod  = (mvf_pkg::ELR_W + mvf_pkg::RECIP_R_W)'(elr_reg)
                     * (mvf_pkg::ELR_W + mvf_pkg::RECIP_R_W)'(mvf_pkg::RECIP_R);
    assign elr_quot  = elr_prod[mvf_pkg::RECIP_R_SHIFT +: 17];
    assign step_next = elq_reg + mvf_pkg::STEP_W'(elr_quot);

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        if (adv)
        begin
            elq_reg  <= mvf_pkg::STEP_W'(el) * mvf_pkg::STEP_W'(q_reg);
            elr_reg  <= mvf_pkg::ELR_W'(el) * mvf_pkg::ELR_W'(r_reg);
            step_reg <= step_next;
        end
    end

    assign step = step_reg;

endmodule

// ----- rtl/mvf_scale.sv -----
// mvf_scale: pipelined value * param_a + param_b with floor to Q16.16 and saturation
// depends on mvf_pkg; output aligned with the last pipeline stage of the top level
module mvf_scale (
    input  logic                clk,
    input  logic                adv,
    input  logic signed [31:0]  value,
    input  logic signed [31:0]  param_a,
    input  logic signed [31:0]  param_b,
    output logic signed [31:0]  scaled
);

    logic signed [mvf_pkg::PROD_W-1:0] prod_reg;
    logic signed [mvf_pkg::PROD_W-1:0] prod_shift;
    logic signed [mvf_pkg::SUM_W-1:0]  sum;
    logic signed [31:0]                scaled_reg;

    // arithmetic shift floors toward minus infinity
    assign prod_shift = prod_reg >>> mvf_pkg::Q_FRAC;
    assign sum        = mvf_pkg::SUM_W'(prod_shift) + mvf_pkg::SUM_W'(param_b);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            prod_reg   <= mvf_pkg::PROD_W'(value) * mvf_pkg::PROD_W'(param_a);
            scaled_reg <= mvf_pkg::sat32(sum);
        end
    end

    assign scaled = scaled_reg;

endmodule

// ----- rtl/mvf_state.sv -----
// mvf_state: filter state (primed, held output, pending target, mark time) and
// per-mode result selection; depends on mvf_pkg
module mvf_state (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        fire,
    input  mvf_pkg::cfg_t               cfg,
    input  logic signed [31:0]          value,
    input  logic [31:0]                 now_ms,
    input  logic [mvf_pkg::STEP_W-1:0]  step,
    input  logic signed [31:0]          scaled,
    output logic signed [31:0]          result,
    output logic                        converging,
    output logic [31:0]                 mark_time
);

    logic               primed_reg, primed_next;
    logic signed [31:0] held_reg, held_next;
    logic signed [31:0] pend_reg, pend_next;
    logic [31:0]        mark_reg, mark_next;

    logic [31:0]        elapsed;
    logic               time_ok;
    logic signed [32:0] diff;
    logic signed [33:0] abs_diff;
    logic signed [39:0] delta;
    logic signed [39:0] step_s;
    logic signed [39:0] clipped;
    logic signed [31:0] rate_out;
    logic signed [31:0] clamp_lo;
    logic signed [31:0] clamp_out;
    logic signed [32:0] gap;
    logic [32:0]        gap_abs;

    assign elapsed = now_ms - mark_reg;
    assign time_ok = (cfg.param_a < mvf_pkg::Q_ONE) || (elapsed >= {16'd0, cfg.param_a[31:16]});

    assign diff     = 33'(value) - 33'(held_reg);
    assign abs_diff = diff[32] ? -34'(diff) : 34'(diff);

    assign delta  = 40'(diff);
    assign step_s = 40'({1'b0, step});

    always_comb
    begin
        clipped = delta;
        if (cfg.param_a > 32'sd0)
        begin
            if (delta > step_s)
                clipped = step_s;
            else if (delta < -step_s)
                clipped = -step_s;
        end
    end

    assign rate_out = mvf_pkg::sat32(mvf_pkg::SUM_W'(held_reg) + mvf_pkg::SUM_W'(clipped));

    assign clamp_lo  = (value < cfg.param_b) ? value : cfg.param_b;
    assign clamp_out = (clamp_lo < cfg.param_a) ? cfg.param_a : clamp_lo;

    always_comb
    begin
        primed_next = primed_reg;
        held_next   = held_reg;
        pend_next   = pend_reg;
        mark_next   = mark_reg;
        result      = value;
        if (cfg.enable)
        begin
            case (mvf_pkg::mode_t'(cfg.mode))
                mvf_pkg::MODE_DELAY:
                begin
                    if (!primed_reg)
                    begin
                        primed_next = 1'b1;
                        held_next   = value;
                        pend_next   = value;
                        mark_next   = now_ms;
                    end
                    else
                    begin
                        pend_next = value;
                        if (time_ok)
                        begin
                            held_next = value;
                            mark_next = now_ms;
                        end
                        result = held_next;
                    end
                end
                mvf_pkg::MODE_DEBOUNCE:
                begin
                    if (!primed_reg)
                    begin
                        primed_next = 1'b1;
                        held_next   = value;
                        pend_next   = value;
                        mark_next   = now_ms;
                    end
                    else
                    begin
                        if (value != pend_reg)
                        begin
                            pend_next = value;
                            mark_next = now_ms;
                        end
                        else if (time_ok)
                            held_next = pend_reg;
                        result = held_next;
                    end
                end
                mvf_pkg::MODE_RATE:
                begin
                    if (!primed_reg)
                    begin
                        primed_next = 1'b1;
                        held_next   = value;
                        pend_next   = value;
                        mark_next   = now_ms;
                    end
                    else
                    begin
                        pend_next = value;
                        mark_next = now_ms;
                        held_next = rate_out;
                        result    = rate_out;
                    end
                end
                mvf_pkg::MODE_DEADZONE:
                begin
                    if (!primed_reg)
                    begin
                        primed_next = 1'b1;
                        held_next   = value;
                    end
                    else if (abs_diff < 34'(cfg.param_a))
                        result = held_reg;
                    else
                        held_next = value;
                end
                mvf_pkg::MODE_CLAMP:
                    result = clamp_out;
                mvf_pkg::MODE_SCALE:
                    result = scaled;
                default:
                    result = value;
            endcase
        end
    end

    assign gap     = 33'(held_next) - 33'(pend_next);
    assign gap_abs = gap[32] ? 33'(-gap) : 33'(gap);

    always_comb
    begin
        converging = 1'b0;
        if (cfg.enable && primed_next)
        begin
            if ((cfg.mode == mvf_pkg::MODE_DELAY) || (cfg.mode == mvf_pkg::MODE_DEBOUNCE))
                converging = (held_next != pend_next);
            else if (cfg.mode == mvf_pkg::MODE_RATE)
                converging = (gap_abs > mvf_pkg::RATE_TOL);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            primed_reg <= 1'b0;
            held_reg   <= '0;
            pend_reg   <= '0;
            mark_reg   <= '0;
        end
        else if (fire)
        begin
            primed_reg <= primed_next;
            held_reg   <= held_next;
            pend_reg   <= pend_next;
            mark_reg   <= mark_next;
        end
    end

    assign mark_time = mark_reg;

endmodule

// ----- rtl/multimode_value_filter_core.sv -----
// multimode_value_filter_core: top level with register port, input pipeline and output register
// depends on mvf_pkg, mvf_rate_step, mvf_scale, mvf_state
// an input transaction passes through p0, p1, p2 and p3, then the output register; one per cycle while adv is high
// the whole pipeline advances when the output register is empty or being taken
// the rate step (two multiplies and a reciprocal divide) sets the pipeline depth
// reset: asynchronous, clears registers, filter state and pipeline valids; no clearing pass
module multimode_value_filter_core (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [mvf_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    input  logic [63:0]                s_axis_tdata,   // sample_value[31:0], now_ms[63:32]
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    output logic [31:0]                m_axis_tdata,   // filtered_value[31:0]
    output logic [0:0]                 m_axis_tuser    // converging[0]
);

    logic                 enable_reg;
    logic [2:0]           mode_reg;
    logic signed [31:0]   param_a_reg;
    logic signed [31:0]   param_b_reg;
    mvf_pkg::cfg_t        cfg;
    logic                 cfg_wr;

    logic                 adv;
    logic                 accept;
    logic [31:0]          early_mark_reg;
    logic [31:0]          el_diff;
    logic [mvf_pkg::EL_W-1:0] el_in;

    logic                 p0_valid_reg, p1_valid_reg, p2_valid_reg, p3_valid_reg;
    logic signed [31:0]   p0_val_reg, p1_val_reg, p2_val_reg, p3_val_reg;
    logic [31:0]          p0_now_reg, p1_now_reg, p2_now_reg, p3_now_reg;
    logic [mvf_pkg::EL_W-1:0] p0_el_reg, p1_el_reg;

    logic [mvf_pkg::STEP_W-1:0] step;
    logic signed [31:0]   scaled;
    logic signed [31:0]   result;
    logic                 converging;
    logic [31:0]          mark_time;

    logic                 out_valid_reg;
    logic signed [31:0]   out_value_reg;
    logic                 out_conv_reg;

    // register port
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg  <= 1'b0;
            mode_reg    <= '0;
            param_a_reg <= '0;
            param_b_reg <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (mvf_pkg::reg_idx_t'(paddr[3:2]))
                mvf_pkg::REG_ENABLE:  enable_reg  <= pwdata[0];
                mvf_pkg::REG_MODE:    mode_reg    <= pwdata[2:0];
                mvf_pkg::REG_PARAM_A: param_a_reg <= pwdata;
                mvf_pkg::REG_PARAM_B: param_b_reg <= pwdata;
            endcase
        end
    end

    always_comb
    begin
        unique case (mvf_pkg::reg_idx_t'(paddr[3:2]))
            mvf_pkg::REG_ENABLE:  prdata = {31'd0, enable_reg};
            mvf_pkg::REG_MODE:    prdata = {29'd0, mode_reg};
            mvf_pkg::REG_PARAM_A: prdata = param_a_reg;
            mvf_pkg::REG_PARAM_B: prdata = param_b_reg;
        endcase
    end

    assign cfg.enable  = enable_reg;
    assign cfg.mode    = mode_reg;
    assign cfg.param_a = param_a_reg;
    assign cfg.param_b = param_b_reg;

    // pipeline control
    assign adv           = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = adv;
    assign accept        = s_axis_tvalid && adv;

    // rate mode restarts the timer on every transaction, so elapsed is known at entry
    assign el_diff = s_axis_tdata[63:32] - early_mark_reg;
    assign el_in   = (el_diff > mvf_pkg::EL_MAX) ? mvf_pkg::EL_MAX[mvf_pkg::EL_W-1:0] :
                     (el_diff == 32'd0)          ? mvf_pkg::EL_W'(1) :
                                                   el_diff[mvf_pkg::EL_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            early_mark_reg <= '0;
        else if (cfg_wr)
            early_mark_reg <= mark_time;
        else if (accept && enable_reg && (mode_reg == mvf_pkg::MODE_RATE))
            early_mark_reg <= s_axis_tdata[63:32];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p0_valid_reg  <= 1'b0;
            p1_valid_reg  <= 1'b0;
            p2_valid_reg  <= 1'b0;
            p3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            p0_valid_reg  <= s_axis_tvalid;
            p1_valid_reg  <= p0_valid_reg;
            p2_valid_reg  <= p1_valid_reg;
            p3_valid_reg  <= p2_valid_reg;
            out_valid_reg <= p3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p0_val_reg <= s_axis_tdata[31:0];
            p0_now_reg <= s_axis_tdata[63:32];
            p0_el_reg  <= el_in;
            p1_val_reg <= p0_val_reg;
            p1_now_reg <= p0_now_reg;
            p1_el_reg  <= p0_el_reg;
            p2_val_reg <= p1_val_reg;
            p2_now_reg <= p1_now_reg;
            p3_val_reg <= p2_val_reg;
            p3_now_reg <= p2_now_reg;
            if (p3_valid_reg)
            begin
                out_value_reg <= result;
                out_conv_reg  <= converging;
            end
        end
    end

    mvf_rate_step u_rate_step (
        .clk     (clk),
        .adv     (adv),
        .param_a (param_a_reg),
        .el      (p1_el_reg),
        .step    (step)
    );

    mvf_scale u_scale (
        .clk     (clk),
        .adv     (adv),
        .value   (p1_val_reg),
        .param_a (param_a_reg),
        .param_b (param_b_reg),
        .scaled  (scaled)
    );

    mvf_state u_state (
        .clk        (clk),
        .rst_n      (rst_n),
        .fire       (p3_valid_reg && adv),
        .cfg        (cfg),
        .value      (p3_val_reg),
        .now_ms     (p3_now_reg),
        .step       (step),
        .scaled     (scaled),
        .result     (result),
        .converging (converging),
        .mark_time  (mark_time)
    );

    assign m_axis_tvalid   = out_valid_reg;
    assign m_axis_tdata    = out_value_reg;
    assign m_axis_tuser[0] = out_conv_reg;

    // entry timer copy matches the filter timer whenever rate mode is idle
    a_early_mark: assert property (@(posedge clk) disable iff (!rst_n)
        (enable_reg && (mode_reg == mvf_pkg::MODE_RATE) && !p0_valid_reg && !p1_valid_reg
         && !p2_valid_reg && !p3_valid_reg) |-> (early_mark_reg == mark_time))
        else $error("entry timer copy out of step with filter timer");

    a_conv_enabled: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser[0]) |-> enable_reg)
        else $error("converging flag set while filter disabled");

    a_pipe_move: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && p3_valid_reg) |=> out_valid_reg)
        else $error("last stage transaction not moved to output register");

endmodule
